// ===== hdl/iprn_pkg.sv =====
// ----------------------------------------------------------------------------
// iprn_pkg
// Shared constants, types and helpers for the 3D gradient noise unit.
// ----------------------------------------------------------------------------
package iprn_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int OUT_W     = 18;
  localparam int CELL_W    = 8;
  localparam int WORK_W    = FRAC_BITS + 10;
  localparam int PROD_W    = 2 * WORK_W;
  localparam int STEP_W    = 5;

  localparam logic signed [WORK_W-1:0] ONE_FX     = WORK_W'(1) << FRAC_BITS;
  localparam logic signed [WORK_W-1:0] TEN_FX     = WORK_W'(10) << FRAC_BITS;
  localparam logic signed [WORK_W-1:0] FIFTEEN_FX = WORK_W'(15) << FRAC_BITS;
  localparam logic signed [WORK_W-1:0] OUT_MAX    = WORK_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [WORK_W-1:0] OUT_MIN    = -(WORK_W'(1 << (OUT_W - 1)));

  // item kinds
  localparam logic MODE_EVAL = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // sequencer steps
  localparam logic [STEP_W-1:0] STEP_FADE_END  = STEP_W'(12);
  localparam logic [STEP_W-1:0] STEP_GRAD_0    = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_GRAD_7    = STEP_W'(14);
  localparam logic [STEP_W-1:0] STEP_LERP_0    = STEP_W'(15);
  localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(23);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  // 12-direction gradient dot product
  function automatic logic signed [WORK_W-1:0] grad(
    input logic [3:0]               h,
    input logic signed [WORK_W-1:0] x,
    input logic signed [WORK_W-1:0] y,
    input logic signed [WORK_W-1:0] z
  );
    logic signed [WORK_W-1:0] u;
    logic signed [WORK_W-1:0] v;
    u = h[3] ? y : x;
    if (h[3:2] == 2'b00) begin
      v = y;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = x;
    end else begin
      v = z;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

// ===== hdl/improved_perlin_noise_3d_unit.sv =====
// ----------------------------------------------------------------------------
// improved_perlin_noise_3d_unit
// Improved 3D gradient noise on Q16.16 points, permutation table in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_axis. tuser selects the kind: 0 evaluates the
//   noise at the point in tdata, 1 writes table_value into table slot
//   table_index. All 256 slots must be loaded before the first evaluation.
//   A load beat gives no output beat.
//   An evaluate beat gives one output beat on m_axis, Q2.16 in tdata.
//   An evaluation runs as a sequence of steps, set by the 14 dependent
//   reads of the table RAM plus the 19 products of the shared multiplier,
//   partly overlapped, one step per cycle unless the sequencer holds on
//   its last step. A new beat is taken only once the evaluation is done.
//   The output sits in a register; a new beat is accepted while it waits.
//   If a second result is ready while the first is still stalled, the
//   sequencer holds on its last step until m_axis_tready.
//   Reset clears the control state; table contents are kept undefined.
// ----------------------------------------------------------------------------
module improved_perlin_noise_3d_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // coord_x[31:0], coord_y[63:32], coord_z[95:64], table_index[103:96],
  // table_value[111:104]
  input  logic [111:0] s_axis_tdata,
  // mode[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // noise_value[17:0], zero pad[23:18]
  output logic [23:0]  m_axis_tdata
);

  localparam int F = iprn_pkg::FRAC_BITS;
  localparam int W = iprn_pkg::WORK_W;
  localparam int CW = iprn_pkg::CELL_W;

  iprn_pkg::state_e state_q, state_d;
  logic [iprn_pkg::STEP_W-1:0] step_q, step_d;

  logic [CW-1:0] mem [256];
  logic [CW-1:0] rdata_q;
  logic [CW-1:0] raddr;

  logic [F-1:0]  frac_q [3];
  logic [CW-1:0] cx_q, cy_q, cz_q;
  logic [CW-1:0] a_q, b_q, aa_q, ab_q, ba_q, bb_q;
  logic signed [W-1:0] inner_q;
  logic signed [W-1:0] fade_q [3];
  logic signed [W-1:0] g_q [8];
  logic signed [W-1:0] lv_q [6];
  logic signed [iprn_pkg::PROD_W-1:0] prod_q;
  logic signed [W-1:0] rs, op_a, op_b, t_cur, gcur, rsum, rsat;
  logic signed [W-1:0] gx, gy, gz;
  logic [2:0] corner;
  logic [1:0] axis;

  logic out_valid_q;
  logic [iprn_pkg::OUT_W-1:0] out_data_q;

  logic s_fire, out_busy, finish;

  assign s_axis_tready = (state_q == iprn_pkg::ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_busy      = out_valid_q && !m_axis_tready;
  assign finish        = (state_q != iprn_pkg::ST_IDLE) && (step_q == iprn_pkg::STEP_LAST)
                         && !out_busy;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};

  // scaled product
  assign rs = $signed(prod_q[F+W-1:F]);

  // table read address per step
  always_comb begin
    case (step_q)
      5'd0:    raddr = cx_q;
      5'd1:    raddr = cx_q + 8'd1;
      5'd2:    raddr = a_q;
      5'd3:    raddr = a_q + 8'd1;
      5'd4:    raddr = b_q;
      5'd5:    raddr = b_q + 8'd1;
      5'd6:    raddr = aa_q;
      5'd7:    raddr = ba_q;
      5'd8:    raddr = ab_q;
      5'd9:    raddr = bb_q;
      5'd10:   raddr = aa_q + 8'd1;
      5'd11:   raddr = ba_q + 8'd1;
      5'd12:   raddr = ab_q + 8'd1;
      5'd13:   raddr = bb_q + 8'd1;
      default: raddr = '0;
    endcase
  end

  // table RAM: loads in idle, reads while running
  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tuser == iprn_pkg::MODE_LOAD) begin
      mem[s_axis_tdata[103:96]] <= s_axis_tdata[111:104];
    end
    rdata_q <= mem[raddr];
  end

  // gradient for the corner whose hash is in rdata_q
  assign corner = 3'(step_q - iprn_pkg::STEP_GRAD_0);
  assign gx = W'(frac_q[0]) - (corner[0] ? iprn_pkg::ONE_FX : '0);
  assign gy = W'(frac_q[1]) - (corner[1] ? iprn_pkg::ONE_FX : '0);
  assign gz = W'(frac_q[2]) - (corner[2] ? iprn_pkg::ONE_FX : '0);
  assign gcur = iprn_pkg::grad(rdata_q[3:0], gx, gy, gz);

  // multiplier operands
  assign axis  = step_q[3:2];
  assign t_cur = (axis < 2'd3) ? W'(frac_q[axis]) : '0;

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (step_q < iprn_pkg::STEP_FADE_END) begin
      case (step_q[1:0])
        2'd0: begin
          op_a = t_cur;
          op_b = (t_cur <<< 2) + (t_cur <<< 1) - iprn_pkg::FIFTEEN_FX;
        end
        2'd1: begin
          op_a = t_cur;
          op_b = t_cur;
        end
        2'd2: begin
          op_a = rs;
          op_b = t_cur;
        end
        default: begin
          op_a = rs;
          op_b = inner_q;
        end
      endcase
    end else begin
      case (step_q)
        5'd15: begin op_a = fade_q[0]; op_b = g_q[1] - g_q[0]; end
        5'd16: begin op_a = fade_q[0]; op_b = g_q[3] - g_q[2]; end
        5'd17: begin op_a = fade_q[0]; op_b = g_q[5] - g_q[4]; end
        5'd18: begin op_a = fade_q[0]; op_b = g_q[7] - g_q[6]; end
        5'd19: begin op_a = fade_q[1]; op_b = lv_q[1] - lv_q[0]; end
        5'd20: begin op_a = fade_q[1]; op_b = lv_q[3] - lv_q[2]; end
        // last product stays in place while the result waits
        5'd22, 5'd23: begin op_a = fade_q[2]; op_b = lv_q[5] - lv_q[4]; end
        default: ;
      endcase
    end
  end

  // final sum and saturation
  assign rsum = lv_q[4] + rs;
  assign rsat = (rsum > iprn_pkg::OUT_MAX) ? iprn_pkg::OUT_MAX :
                (rsum < iprn_pkg::OUT_MIN) ? iprn_pkg::OUT_MIN : rsum;

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    if (s_fire && s_axis_tuser == iprn_pkg::MODE_EVAL) begin
      cx_q      <= s_axis_tdata[F+CW-1:F];
      cy_q      <= s_axis_tdata[32+F+CW-1:32+F];
      cz_q      <= s_axis_tdata[64+F+CW-1:64+F];
      frac_q[0] <= s_axis_tdata[F-1:0];
      frac_q[1] <= s_axis_tdata[32+F-1:32];
      frac_q[2] <= s_axis_tdata[64+F-1:64];
    end
    if (state_q == iprn_pkg::ST_RUN) begin
      if (step_q < iprn_pkg::STEP_FADE_END && step_q[1:0] == 2'd1) begin
        inner_q <= rs + iprn_pkg::TEN_FX;
      end
      case (step_q)
        5'd1:  a_q  <= rdata_q + cy_q;
        5'd2:  b_q  <= rdata_q + cy_q;
        5'd3:  aa_q <= rdata_q + cz_q;
        5'd4: begin
          ab_q      <= rdata_q + cz_q;
          fade_q[0] <= rs;
        end
        5'd5:  ba_q <= rdata_q + cz_q;
        5'd6:  bb_q <= rdata_q + cz_q;
        5'd8:  fade_q[1] <= rs;
        5'd12: fade_q[2] <= rs;
        5'd16: lv_q[0] <= g_q[0] + rs;
        5'd17: lv_q[1] <= g_q[2] + rs;
        5'd18: lv_q[2] <= g_q[4] + rs;
        5'd19: lv_q[3] <= g_q[6] + rs;
        5'd20: lv_q[4] <= lv_q[0] + rs;
        5'd21: lv_q[5] <= lv_q[2] + rs;
        default: ;
      endcase
      if (step_q >= iprn_pkg::STEP_GRAD_0 && step_q <= iprn_pkg::STEP_GRAD_7) begin
        g_q[corner] <= gcur;
      end
    end
    if (finish) begin
      out_data_q <= rsat[iprn_pkg::OUT_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      iprn_pkg::ST_IDLE: begin
        if (s_fire && s_axis_tuser == iprn_pkg::MODE_EVAL) begin
          state_d = iprn_pkg::ST_RUN;
          step_d  = '0;
        end
      end
      iprn_pkg::ST_RUN: begin
        if (finish) begin
          state_d = iprn_pkg::ST_IDLE;
        end else if (step_q == iprn_pkg::STEP_LAST) begin
          state_d = iprn_pkg::ST_HOLD;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      iprn_pkg::ST_HOLD: begin
        if (finish) begin
          state_d = iprn_pkg::ST_IDLE;
        end
      end
      default: state_d = iprn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iprn_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= finish || out_busy;
    end
  end

endmodule

// ===== hdl/iprn_checker.sv =====
// ----------------------------------------------------------------------------
// iprn_checker
// Port-level checks for the gradient noise unit, bound to the top level.
// ----------------------------------------------------------------------------
module iprn_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [111:0] s_axis_tdata,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [23:0]  m_axis_tdata
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed under stall");

  // an evaluation keeps the input side busy
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == iprn_pkg::MODE_EVAL
    |=> !s_axis_tready)
    else $error("input accepted during evaluation");

  // a load never makes a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == iprn_pkg::MODE_LOAD
    && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result after table load");

  // pad bits stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
    else $error("nonzero pad in output beat");

endmodule

bind improved_perlin_noise_3d_unit iprn_checker u_iprn_checker (.*);
